/* hw/rtl/laa_pkg.sv */
// shared constants, types and tables for the look-at angle unit
`timescale 1ns / 1ps
package laa_pkg;
   localparam int COORD_WIDTH_DEF      = 24;
   localparam int ANGLE_ITERATIONS_DEF = 16;
   localparam int DATA_W   = 43;   // guarded coordinates plus cordic growth
   localparam int ANG_W    = 21;   // internal q.16 angle
   localparam int Q_DEPTH  = 4;
   localparam int Q_AW     = 2;
   localparam logic signed [ANG_W-1:0] HALF_PI_Q16 = 21'sd102944;
   localparam logic signed [ANG_W-1:0] TWO_PI_Q16  = 21'sd411775;
   localparam logic [15:0]             TWO_PI_Q13  = 16'd51472;
   localparam logic signed [14:0]      HALF_PI_Q13 = 15'sd12868;
   localparam logic [15:0]             INV_GAIN_Q16 = 16'd39797;

   // word handed from the front to the back through the queue
   typedef struct packed {
      logic signed [DATA_W-1:0] cx;
      logic signed [DATA_W-1:0] cy;
      logic signed [DATA_W-1:0] sy;
      logic signed [ANG_W-1:0]  z0;
      logic                     degen;
      logic signed [14:0]       degen_pitch;
   } front_word_type;

   function automatic logic signed [ANG_W-1:0] atan_entry(input int i);
      logic signed [ANG_W-1:0] r;
      begin
         case (i)
            0: r = 21'sd51472;  1: r = 21'sd30386;  2: r = 21'sd16055;
            3: r = 21'sd8150;   4: r = 21'sd4091;   5: r = 21'sd2047;
            6: r = 21'sd1024;   7: r = 21'sd512;    8: r = 21'sd256;
            9: r = 21'sd128;    10: r = 21'sd64;    11: r = 21'sd32;
            12: r = 21'sd16;    13: r = 21'sd8;     14: r = 21'sd4;
            15: r = 21'sd2;     16: r = 21'sd1;
            default: r = '0;
         endcase
         return r;
      end
   endfunction
endpackage

/* hw/rtl/laa_front.sv */
// front stage: differences, degenerate check and quadrant pre-rotation
`timescale 1ns / 1ps
module laa_front #(
   parameter int COORD_WIDTH = laa_pkg::COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [COORD_WIDTH-1:0] cam_x,
   input  logic signed [COORD_WIDTH-1:0] cam_y,
   input  logic signed [COORD_WIDTH-1:0] cam_z,
   input  logic signed [COORD_WIDTH-1:0] tgt_x,
   input  logic signed [COORD_WIDTH-1:0] tgt_y,
   input  logic signed [COORD_WIDTH-1:0] tgt_z,
   output logic                          out_valid,
   input  logic                          out_ready,
   output laa_pkg::front_word_type       out_word
);
   localparam int GUARD = 40 - COORD_WIDTH;
   localparam int W = laa_pkg::DATA_W;

   logic                    valid_ff, valid_in;
   laa_pkg::front_word_type word_ff, word_in;
   logic signed [W-1:0]     sx, sy, sz;

   always_comb begin
      sx = W'(signed'({cam_x[COORD_WIDTH-1], cam_x}) - signed'({tgt_x[COORD_WIDTH-1], tgt_x}))
           <<< GUARD;
      sy = W'(signed'({cam_y[COORD_WIDTH-1], cam_y}) - signed'({tgt_y[COORD_WIDTH-1], tgt_y}))
           <<< GUARD;
      sz = W'(signed'({cam_z[COORD_WIDTH-1], cam_z}) - signed'({tgt_z[COORD_WIDTH-1], tgt_z}))
           <<< GUARD;
      word_in.sy = sy;
      word_in.degen = (sx == '0) && (sz == '0);
      if (sy > 0)      word_in.degen_pitch = laa_pkg::HALF_PI_Q13;
      else if (sy < 0) word_in.degen_pitch = -laa_pkg::HALF_PI_Q13;
      else             word_in.degen_pitch = '0;
      // fold the left half plane onto the right one
      if (sz >= 0) begin
         word_in.cx = sz; word_in.cy = sx; word_in.z0 = '0;
      end else if (sx >= 0) begin
         word_in.cx = sx; word_in.cy = -sz; word_in.z0 = laa_pkg::HALF_PI_Q16;
      end else begin
         word_in.cx = -sx; word_in.cy = sz; word_in.z0 = -laa_pkg::HALF_PI_Q16;
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = (in_valid && in_ready) || (valid_ff && !out_ready);
   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
      if (in_valid && in_ready) word_ff <= word_in;
   end
endmodule

/* hw/rtl/laa_queue.sv */
// short fifo between front and back
`timescale 1ns / 1ps
module laa_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  laa_pkg::front_word_type in_word,
   output logic                    out_valid,
   input  logic                    out_ready,
   output laa_pkg::front_word_type out_word
);
   localparam int AW = laa_pkg::Q_AW;
   laa_pkg::front_word_type mem_ff [laa_pkg::Q_DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic          push, pop;

   assign in_ready  = cnt_ff != (AW+1)'(laa_pkg::Q_DEPTH);
   assign out_valid = cnt_ff != '0;
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;
   assign out_word = mem_ff[rd_ff];
   assign wr_in  = push ? wr_ff + 1'b1 : wr_ff;
   assign rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
   assign cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= in_word;
   end

`ifndef SYNTH
   a_no_over: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (AW+1)'(laa_pkg::Q_DEPTH)) else $error("queue overflow");
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + 1'b1) else $error("count slip");
   a_empty: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == '0 |-> !out_valid) else $error("empty pop");
`endif
endmodule

/* hw/rtl/laa_back.sv */
// back end: pipelined cordic for yaw, gain scale, cordic for pitch
`timescale 1ns / 1ps
module laa_back #(
   parameter int ANGLE_ITERATIONS = laa_pkg::ANGLE_ITERATIONS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  laa_pkg::front_word_type in_word,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [15:0]             yaw,
   output logic signed [14:0]      pitch,
   output logic                    degen
);
   localparam int W = laa_pkg::DATA_W;
   localparam int A = laa_pkg::ANG_W;
   localparam int N = ANGLE_ITERATIONS;
   // yaw stages 0..N-1, scale stages N,N+1, pitch N+2..2N+1, finish 2N+2
   localparam int S = 2 * N + 3;

   logic                vld_ff [S+1];
   logic signed [W-1:0] x_ff [S+1], y_ff [S+1], sy_ff [S+1];
   logic signed [A-1:0] z_ff [S+1], yz_ff [S+1];
   logic                dg_ff [S+1];
   logic signed [14:0]  dp_ff [S+1];
   logic [W+15:0]       prod_ff;
   logic                adv;

   // pipeline moves only when the output slot is free
   assign adv      = !vld_ff[S] || out_ready;
   assign in_ready = adv;
   assign out_valid = vld_ff[S];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= S; k++) vld_ff[k] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= in_valid;
         for (int k = 1; k <= S; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff[0] <= in_word.cx; y_ff[0] <= in_word.cy; z_ff[0] <= in_word.z0;
         sy_ff[0] <= in_word.sy;
         dg_ff[0] <= in_word.degen; dp_ff[0] <= in_word.degen_pitch;
         for (int k = 1; k <= S; k++) begin
            dg_ff[k] <= dg_ff[k-1]; dp_ff[k] <= dp_ff[k-1];
         end
         for (int k = 1; k <= N + 1; k++) sy_ff[k] <= sy_ff[k-1];
         for (int k = N + 2; k <= S; k++) yz_ff[k] <= yz_ff[k-1];
         z_ff[S] <= z_ff[S-1];
         // yaw micro-rotations
         for (int i = 0; i < N; i++) begin
            if (y_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + laa_pkg::atan_entry(i);
            end else begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - laa_pkg::atan_entry(i);
            end
         end
         // stage N: wrap yaw, multiply clamped length by inverse gain
         yz_ff[N+1] <= (z_ff[N] < 0) ? z_ff[N] + laa_pkg::TWO_PI_Q16 : z_ff[N];
         prod_ff <= (x_ff[N] < 0) ? '0
                    : (W+16)'(x_ff[N]) * (W+16)'(laa_pkg::INV_GAIN_Q16);
         // stage N+1: round to horizontal length, start pitch pass
         x_ff[N+2] <= W'((prod_ff + (W+16)'(32768)) >> 16);
         y_ff[N+2] <= sy_ff[N+1];
         z_ff[N+2] <= '0;
         for (int i = 0; i < N; i++) begin
            if (y_ff[N+2+i] >= 0) begin
               x_ff[N+3+i] <= x_ff[N+2+i] + (y_ff[N+2+i] >>> i);
               y_ff[N+3+i] <= y_ff[N+2+i] - (x_ff[N+2+i] >>> i);
               z_ff[N+3+i] <= z_ff[N+2+i] + laa_pkg::atan_entry(i);
            end else begin
               x_ff[N+3+i] <= x_ff[N+2+i] - (y_ff[N+2+i] >>> i);
               y_ff[N+3+i] <= y_ff[N+2+i] + (x_ff[N+2+i] >>> i);
               z_ff[N+3+i] <= z_ff[N+2+i] - laa_pkg::atan_entry(i);
            end
         end
      end
   end

   logic signed [A-1:0] yz, rz, pr;
   always_comb begin
      yz = (yz_ff[S] < 0) ? '0 : yz_ff[S];
      rz = (yz + A'(4)) >>> 3;
      pr = (z_ff[S] + A'(4)) >>> 3;
      if (dg_ff[S]) begin
         yaw = '0; pitch = dp_ff[S];
      end else begin
         yaw = (rz >= A'(laa_pkg::TWO_PI_Q13)) ? '0 : rz[15:0];
         if (pr > A'(laa_pkg::HALF_PI_Q13))        pitch = laa_pkg::HALF_PI_Q13;
         else if (pr < -A'(laa_pkg::HALF_PI_Q13))  pitch = -laa_pkg::HALF_PI_Q13;
         else                                       pitch = pr[14:0];
      end
      degen = dg_ff[S];
   end

`ifndef SYNTH
   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid) else $error("word dropped");
   a_yaw: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> yaw < laa_pkg::TWO_PI_Q13) else $error("yaw range");
   a_deg: assert property (@(posedge clock) disable iff (reset)
      out_valid && degen |-> yaw == '0) else $error("degenerate yaw");
`endif
endmodule

/* hw/rtl/look_at_angle_unit.sv */
// top level of the look-at angle unit
// channel  ports       dir  meaning
// req      req_*       in   camera and target coordinates
// rsp      rsp_*       out  yaw, pitch, degenerate flag
// one word accepted per cycle while req_ready is high; each word passes through
// the two chained cordic pipelines and the gain multiply
// reset clears all valid bits and the queue; no clearing pass
// a stalled rsp side fills the queue, then deasserts req_ready
`timescale 1ns / 1ps
module look_at_angle_unit #(
   parameter int COORD_WIDTH      = laa_pkg::COORD_WIDTH_DEF,
   parameter int ANGLE_ITERATIONS = laa_pkg::ANGLE_ITERATIONS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_camera_x,
   input  logic signed [COORD_WIDTH-1:0] req_camera_y,
   input  logic signed [COORD_WIDTH-1:0] req_camera_z,
   input  logic signed [COORD_WIDTH-1:0] req_target_x,
   input  logic signed [COORD_WIDTH-1:0] req_target_y,
   input  logic signed [COORD_WIDTH-1:0] req_target_z,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [15:0]                   rsp_yaw_angle,
   output logic signed [14:0]            rsp_pitch_angle,
   output logic                          rsp_degenerate
);
   logic f_valid, f_ready, q_valid, q_ready;
   laa_pkg::front_word_type f_word, q_word;

   laa_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock, .reset, .in_valid(req_valid), .in_ready(req_ready),
      .cam_x(req_camera_x), .cam_y(req_camera_y), .cam_z(req_camera_z),
      .tgt_x(req_target_x), .tgt_y(req_target_y), .tgt_z(req_target_z),
      .out_valid(f_valid), .out_ready(f_ready), .out_word(f_word));

   laa_queue u_queue (
      .clock, .reset, .in_valid(f_valid), .in_ready(f_ready), .in_word(f_word),
      .out_valid(q_valid), .out_ready(q_ready), .out_word(q_word));

   laa_back #(.ANGLE_ITERATIONS(ANGLE_ITERATIONS)) u_back (
      .clock, .reset, .in_valid(q_valid), .in_ready(q_ready), .in_word(q_word),
      .out_valid(rsp_valid), .out_ready(rsp_ready), .yaw(rsp_yaw_angle),
      .pitch(rsp_pitch_angle), .degen(rsp_degenerate));
endmodule

/* bench/look_at_angle_unit_tb.sv */
// testbench for the look-at angle unit: predicted yaw, pitch and degenerate flag
`timescale 1ns / 1ps
module look_at_angle_unit_tb;
   localparam int CW = laa_pkg::COORD_WIDTH_DEF;
   localparam int NITER = laa_pkg::ANGLE_ITERATIONS_DEF;
   localparam int GUARD = 40 - CW;
   localparam int N_RANDOM = 800;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct {
      logic [15:0]        yaw;
      logic signed [14:0] pitch;
      logic               degen;
   } aim_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [CW-1:0] req_camera_x = '0, req_camera_y = '0, req_camera_z = '0;
   logic signed [CW-1:0] req_target_x = '0, req_target_y = '0, req_target_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [15:0] rsp_yaw_angle;
   logic signed [14:0] rsp_pitch_angle;
   logic rsp_degenerate;

   int mismatches = 0;
   longint cycle_count = 0;
   bit calm = 1'b0;

   always #5 clock = ~clock;

   look_at_angle_unit u_dut (.*);

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
      mismatches++;
   endtask

   function automatic longint atan_q16(input int i);
      longint t[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                        256, 128, 64, 32, 16, 8, 4, 2, 1};
      return (i < 17) ? t[i] : 0;
   endfunction

   // vector rotation toward the x axis; >>> on longint is floor shift
   function automatic longint rotate_to_axis(input longint x0, input longint y0,
                                             inout longint ang);
      longint x, y, xs, ys;
      x = x0; y = y0;
      for (int i = 0; i < NITER; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x += ys; y -= xs; ang += atan_q16(i);
         end else begin
            x -= ys; y += xs; ang -= atan_q16(i);
         end
      end
      return x;
   endfunction

   function automatic aim_word_type aim_angles(input longint cx_, cy_, cz_, tx, ty, tz);
      aim_word_type r;
      longint dx, dy, dz, sx, sy, sz, vx, vy, z, xf, h, pz, rz, p;
      dx = cx_ - tx; dy = cy_ - ty; dz = cz_ - tz;
      r.yaw = 0; r.pitch = 0; r.degen = 0;
      if (dx == 0 && dz == 0) begin
         r.degen = 1;
         if (dy > 0) r.pitch = laa_pkg::HALF_PI_Q13;
         else if (dy < 0) r.pitch = -laa_pkg::HALF_PI_Q13;
         return r;
      end
      sx = dx <<< GUARD; sy = dy <<< GUARD; sz = dz <<< GUARD;
      vx = sz; vy = sx; z = 0;
      if (vx < 0) begin
         if (vy >= 0) begin
            vx = sx; vy = -sz; z = 102944;
         end else begin
            vx = -sx; vy = sz; z = -102944;
         end
      end
      xf = rotate_to_axis(vx, vy, z);
      if (z < 0) z += 411775;
      if (z < 0) z = 0;
      rz = (z + 4) >>> 3;
      if (rz >= 51472) rz = 0;
      r.yaw = rz[15:0];
      if (xf < 0) xf = 0;
      h = (xf * 39797 + 32768) >>> 16;
      pz = 0;
      void'(rotate_to_axis(h, sy, pz));
      p = (pz + 4) >>> 3;
      if (p > 12868) p = 12868;
      if (p < -12868) p = -12868;
      r.pitch = p[14:0];
      return r;
   endfunction

   class aim_scoreboard;
      aim_word_type pending[$];
      function void note_request(input aim_word_type w);
         pending.push_back(w);
      endfunction
      task check_result(input logic [15:0] yaw, input logic signed [14:0] pitch,
                        input logic degen);
         aim_word_type w;
         if (pending.size() == 0) begin
            report("unexpected word", 0, 0);
            return;
         end
         w = pending.pop_front();
         if (yaw !== w.yaw) report("yaw", yaw, w.yaw);
         if (pitch !== w.pitch) report("pitch", pitch, w.pitch);
         if (degen !== w.degen) report("degenerate", degen, w.degen);
      endtask
   endclass

   aim_scoreboard board = new();

   // note accepted words and check results at the edge
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (req_valid && req_ready)
            board.note_request(aim_angles(req_camera_x, req_camera_y, req_camera_z,
                                          req_target_x, req_target_y, req_target_z));
         if (rsp_valid && rsp_ready)
            board.check_result(rsp_yaw_angle, rsp_pitch_angle, rsp_degenerate);
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // receiver stalls in bursts
   initial begin
      int n;
      @(negedge reset);
      forever begin
         n = $urandom_range(1, 30);
         repeat (n) @(posedge clock) rsp_ready <= 1'b1;
         if (!calm) begin
            n = $urandom_range(1, 14);
            repeat (n) @(posedge clock) rsp_ready <= 1'b0;
         end
      end
   end

   task automatic send(input logic signed [CW-1:0] cx_, cy_, cz_, tx, ty, tz);
      req_valid <= 1'b1;
      req_camera_x <= cx_; req_camera_y <= cy_; req_camera_z <= cz_;
      req_target_x <= tx; req_target_y <= ty; req_target_z <= tz;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic pause_sender();
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   function automatic logic signed [CW-1:0] rand_coord(input int mode);
      logic signed [CW-1:0] v;
      case (mode)
         0: v = CW'($urandom);
         1: v = CW'(int'($urandom_range(0, 2048)) - 1024);
         2: v = ($urandom_range(0, 1)) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
         default: v = CW'(int'($urandom_range(0, 3)) - 1);
      endcase
      return v;
   endfunction

   initial begin
      logic signed [CW-1:0] mx, mn, a, b, c;
      int m;
      mx = {1'b0, {(CW-1){1'b1}}};
      mn = {1'b1, {(CW-1){1'b0}}};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // zero vector, vertical up and down, axis directions, extremes
      send(0, 0, 0, 0, 0, 0);
      send(5, 100, 7, 5, 0, 7);
      send(5, -100, 7, 5, 0, 7);
      send(mx, mx, 0, mn, mn, 0);
      send(mn, mn, 0, mx, mx, 0);
      send(0, 0, 1, 0, 0, 0);
      send(0, 0, -1, 0, 0, 0);
      send(1, 0, 0, 0, 0, 0);
      send(-1, 0, 0, 0, 0, 0);
      send(-1, 0, -256, 0, 0, 0);
      send(1, 0, -256, 0, 0, 0);
      send(mx, 0, mx, mn, 0, mn);
      send(mn, mx, mn, mx, mn, mx);
      send(mx, mn, mn, mn, mx, mx);
      send(256, 256, 256, 0, 0, 0);
      send(0, mx, 1, 0, mn, 0);
      send(-1, 0, mn, 0, 0, mx);
      send(mn, 0, -1, mx, 0, 0);
      send(-256, -1, 1, 0, 0, 0);
      send(mx, mx, mx, mx, mx, mx);
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i > N_RANDOM * 7 / 8) calm = 1'b1;
         pause_sender();
         m = $urandom_range(0, 9);
         m = (m < 5) ? 0 : (m < 8) ? 1 : (m < 9) ? 2 : 3;
         a = rand_coord(m); b = rand_coord(m); c = rand_coord(m);
         if ($urandom_range(0, 19) == 0)
            send(a, b, c, a, rand_coord(0), c);
         else
            send(a, b, c, rand_coord(m), rand_coord(m), rand_coord(m));
      end
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (2 * NITER + 20) @(posedge clock);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
